// ----- rtl/core/rgbhsv_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rgbhsv_pkg - shared constants and types of the RGB to HSV converter
// Channel and result widths, divider datapath widths and the hue sector code.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

   localparam int FRACTION_BITS_DEF = 16;   // default fraction width of hue/saturation
   localparam int COLOR_W           = 8;    // width of one color channel
   localparam int RESULT_W          = 16;   // width of the hue and saturation results
   localparam int SAT_DIV_W         = 8;    // saturation divisor: max, up to 255
   localparam int HUE_DIV_W         = 11;   // hue divisor: 6 * (max - min), up to 1530

   // Channel that holds the maximum; ties resolve red, then green, then blue
   typedef enum logic [1:0] {
      SECT_RED,
      SECT_GREEN,
      SECT_BLUE
   } sector_type;

endpackage : rgbhsv_pkg
`default_nettype wire

// ----- rtl/core/rgb_to_hsv_converter.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter - streaming RGB to HSV pixel converter
// Converts one 8-bit RGB pixel per clock, unless the receiver stalls, into hue, saturation and brightness.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats arrive on req_valid/req_ready with req_red, req_green and
//   req_blue. Result beats leave on rsp_valid/rsp_ready with rsp_hue,
//   rsp_saturation and rsp_brightness. Each input beat yields one result beat,
//   in order.
//   Brightness is the largest channel. Saturation is (max-min)/max and hue is
//   the angle as a fraction of a full turn, both with FRACTION_BITS fraction
//   bits, rounded down, saturation capped at all ones. Grey and black pixels
//   give hue and saturation 0.
//   From the accepting edge to the result on the outputs a pixel passes
//   through FRACTION_BITS + 2 registers: one front stage (max/min/sector), one
//   stage per quotient bit in the two dividers running side by side (hue
//   numerator and divisor setup sit ahead of the first), and the output
//   register. Throughput is one pixel per clock unless the receiver stalls.
//   Reset clears all valid bits; the pipeline comes up empty and ready.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and req_ready drops; nothing is lost or repeated. While the output
//   register is empty or being drained, a new beat is taken every cycle.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter
   import rgbhsv_pkg::*;
#(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [COLOR_W-1:0]  req_red,
   input  wire logic [COLOR_W-1:0]  req_green,
   input  wire logic [COLOR_W-1:0]  req_blue,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [RESULT_W-1:0]      rsp_hue,
   output logic [RESULT_W-1:0]      rsp_saturation,
   output logic [COLOR_W-1:0]       rsp_brightness
);

   // front stage, divider stages, output stage
   localparam int STAGES = FRACTION_BITS + 2;

   typedef struct packed {
      logic [COLOR_W-1:0] hi;     // brightness
      logic               zero;   // grey or black: force hue and saturation to 0
      logic               full;   // min is 0: saturation quotient is a whole one
   } side_type;

   // Global advance: move every stage when the output register can take a beat
   logic enable;
   assign enable    = !rsp_valid || rsp_ready;
   assign req_ready = enable;

   // ---------------------------------------------------------------------------
   // Valid bits travel alongside the data
   // ---------------------------------------------------------------------------
   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;

   assign valid_in = {valid_ff[STAGES-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff[STAGES-1];

   // ---------------------------------------------------------------------------
   // Stage 1: max, min, sector and the signed channel difference of the sector
   // ---------------------------------------------------------------------------
   logic [COLOR_W-1:0] hi_in;
   logic [COLOR_W-1:0] lo_in;
   logic [COLOR_W:0]   span_in;
   sector_type         sector_in;
   logic [COLOR_W:0]   diff_in;     // two's complement, one bit wider than a channel

   always_comb begin
      logic [COLOR_W-1:0] lo_rg;
      lo_rg = (req_red < req_green) ? req_red : req_green;
      lo_in = (lo_rg < req_blue) ? lo_rg : req_blue;
      if (req_red >= req_green && req_red >= req_blue) begin
         sector_in = SECT_RED;
         hi_in     = req_red;
         diff_in   = {1'b0, req_green} - {1'b0, req_blue};
      end else if (req_green >= req_blue) begin
         sector_in = SECT_GREEN;
         hi_in     = req_green;
         diff_in   = {1'b0, req_blue} - {1'b0, req_red};
      end else begin
         sector_in = SECT_BLUE;
         hi_in     = req_blue;
         diff_in   = {1'b0, req_red} - {1'b0, req_green};
      end
      span_in = {1'b0, hi_in} - {1'b0, lo_in};
   end

   logic [COLOR_W-1:0] s1_hi_ff;
   logic [COLOR_W-1:0] s1_span_ff;
   sector_type         s1_sector_ff;
   logic [COLOR_W:0]   s1_diff_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         s1_hi_ff     <= hi_in;
         s1_span_ff   <= span_in[COLOR_W-1:0];
         s1_sector_ff <= sector_in;
         s1_diff_ff   <= diff_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 2: hue numerator in [0, 6d), divisor 6d, saturation start remainder
   // ---------------------------------------------------------------------------
   logic [HUE_DIV_W-1:0] six_span;
   logic [HUE_DIV_W:0]   num_wide;
   logic [HUE_DIV_W:0]   diff_ext;
   logic [HUE_DIV_W:0]   span_ext;
   logic                 full_in;
   logic [SAT_DIV_W-1:0] sat_rem_in;

   assign span_ext = {{(HUE_DIV_W + 1 - COLOR_W){1'b0}}, s1_span_ff};
   assign diff_ext = {{(HUE_DIV_W - COLOR_W){s1_diff_ff[COLOR_W]}}, s1_diff_ff};
   assign six_span = HUE_DIV_W'((span_ext << 2) + (span_ext << 1));

   always_comb begin
      case (s1_sector_ff)
         SECT_RED: begin
            // wrap a negative red-sector angle by one full turn
            num_wide = s1_diff_ff[COLOR_W] ? diff_ext + {1'b0, six_span} : diff_ext;
         end
         SECT_GREEN: num_wide = diff_ext + (span_ext << 1);
         SECT_BLUE:  num_wide = diff_ext + (span_ext << 2);
         default:    num_wide = '0;
      endcase
   end

   // d == max only when min is 0; the quotient would be exactly one
   assign full_in    = (s1_span_ff == s1_hi_ff);
   assign sat_rem_in = full_in ? '0 : s1_span_ff;

   side_type side_ff [FRACTION_BITS];
   side_type side_in;

   assign side_in = '{hi: s1_hi_ff, zero: (s1_span_ff == '0), full: full_in};

   // ---------------------------------------------------------------------------
   // Dividers: saturation = d / max, hue = n / 6d, one quotient bit per stage
   // ---------------------------------------------------------------------------
   logic [FRACTION_BITS-1:0] sat_quo;
   logic [FRACTION_BITS-1:0] hue_quo;

   rgbhsv_divpipe #(
      .STEPS (FRACTION_BITS),
      .DW    (SAT_DIV_W)
   ) u_sat_div (
      .clock     (clock),
      .enable    (enable),
      .rem_start (sat_rem_in),
      .div_start (s1_hi_ff),
      .quotient  (sat_quo)
   );

   rgbhsv_divpipe #(
      .STEPS (FRACTION_BITS),
      .DW    (HUE_DIV_W)
   ) u_hue_div (
      .clock     (clock),
      .enable    (enable),
      .rem_start (num_wide[HUE_DIV_W-1:0]),
      .div_start (six_span),
      .quotient  (hue_quo)
   );

   // Carry brightness and flags in step with the divider stages
   always_ff @(posedge clock) begin
      if (enable) begin
         side_ff[0] <= side_in;
         for (int k = 1; k < FRACTION_BITS; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Output stage: saturate, fit to the result width, clear grey pixels
   // ---------------------------------------------------------------------------
   side_type                 side_out;
   logic [FRACTION_BITS-1:0] sat_val;
   logic [RESULT_W-1:0]      sat_fit;
   logic [RESULT_W-1:0]      hue_fit;

   assign side_out = side_ff[FRACTION_BITS-1];
   assign sat_val  = side_out.full ? '1 : sat_quo;

   generate
      if (FRACTION_BITS > RESULT_W) begin : g_wide
         assign sat_fit = (|sat_val[FRACTION_BITS-1:RESULT_W]) ? '1 : sat_val[RESULT_W-1:0];
         assign hue_fit = hue_quo[RESULT_W-1:0];
      end else begin : g_narrow
         assign sat_fit = RESULT_W'(sat_val);
         assign hue_fit = RESULT_W'(hue_quo);
      end
   endgenerate

   logic [RESULT_W-1:0] rsp_hue_ff;
   logic [RESULT_W-1:0] rsp_saturation_ff;
   logic [COLOR_W-1:0]  rsp_brightness_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_hue_ff        <= side_out.zero ? '0 : hue_fit;
         rsp_saturation_ff <= side_out.zero ? '0 : sat_fit;
         rsp_brightness_ff <= side_out.hi;
      end
   end

   assign rsp_hue        = rsp_hue_ff;
   assign rsp_saturation = rsp_saturation_ff;
   assign rsp_brightness = rsp_brightness_ff;

endmodule : rgb_to_hsv_converter
`default_nettype wire

// ----- rtl/core/rgbhsv_divpipe.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rgbhsv_divpipe - pipelined restoring divider, one quotient bit per stage
// Takes a remainder below the divisor and produces floor(rem * 2^STEPS / div).
// ----------------------------------------------------------------------------
module rgbhsv_divpipe
   import rgbhsv_pkg::*;
#(
   parameter int STEPS = FRACTION_BITS_DEF,
   parameter int DW    = SAT_DIV_W
) (
   input  wire logic             clock,
   input  wire logic             enable,
   input  wire logic [DW-1:0]    rem_start,
   input  wire logic [DW-1:0]    div_start,
   output logic      [STEPS-1:0] quotient
);

   logic [DW-1:0]    rem_ff [STEPS];
   logic [DW-1:0]    div_ff [STEPS];
   logic [STEPS-1:0] quo_ff [STEPS];

   genvar i;
   generate
      for (i = 0; i < STEPS; i++) begin : g_step
         logic [DW-1:0]    rem_prev;
         logic [DW-1:0]    div_prev;
         logic [STEPS-1:0] quo_prev;
         logic [DW:0]      shifted;
         logic [DW:0]      diff;
         logic             take;
         logic [DW-1:0]    rem_in;
         logic [STEPS-1:0] quo_in;

         if (i == 0) begin : g_first
            assign rem_prev = rem_start;
            assign div_prev = div_start;
            assign quo_prev = '0;
         end else begin : g_next
            assign rem_prev = rem_ff[i-1];
            assign div_prev = div_ff[i-1];
            assign quo_prev = quo_ff[i-1];
         end

         // shift in a zero bit, subtract the divisor where it fits
         assign shifted = {rem_prev, 1'b0};
         assign diff    = shifted - {1'b0, div_prev};
         assign take    = (shifted >= {1'b0, div_prev});
         assign rem_in  = take ? diff[DW-1:0] : shifted[DW-1:0];
         assign quo_in  = {quo_prev[STEPS-2:0], take};

         always_ff @(posedge clock) begin
            if (enable) begin
               rem_ff[i] <= rem_in;
               div_ff[i] <= div_prev;
               quo_ff[i] <= quo_in;
            end
         end
      end
   endgenerate

   assign quotient = quo_ff[STEPS-1];

endmodule : rgbhsv_divpipe
`default_nettype wire
